### sv/hcae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcae_pkg
// Shared codes and controller/datapath interface types for the evictor.
// ----------------------------------------------------------------------------
package hcae_pkg;

    localparam logic [15:0] EMPTY_HANDLE = 16'hFFFF;

    // operation codes
    localparam logic [2:0] MODE_NEW   = 3'd0;
    localparam logic [2:0] MODE_SET   = 3'd1;
    localparam logic [2:0] MODE_RESET = 3'd2;
    localparam logic [2:0] MODE_GET   = 3'd3;
    localparam logic [2:0] MODE_DRAIN = 3'd4;
    localparam logic [2:0] MODE_TICK  = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_ID   = 3'd1;
    localparam logic [2:0] ST_EXHAUST  = 3'd2;
    localparam logic [2:0] ST_BOUND    = 3'd3;
    localparam logic [2:0] ST_EMPTY_H  = 3'd4;
    localparam logic [2:0] ST_OVER_CAP = 3'd5;
    localparam logic [2:0] ST_NOTHING  = 3'd6;

    // result value sources
    localparam logic [2:0] VS_ZERO  = 3'd0;
    localparam logic [2:0] VS_NEWID = 3'd1;
    localparam logic [2:0] VS_HD    = 3'd2;
    localparam logic [2:0] VS_EVB   = 3'd3;
    localparam logic [2:0] VS_PEND  = 3'd4;

    typedef struct packed {
        logic       accept;
        logic       rd_scan;
        logic       scan_clr;
        logic       scan_inc;
        logic       ev_cmp;
        logic       tk_load;
        logic       do_new;
        logic       do_bind;
        logic       do_unbind;
        logic       do_get;
        logic       do_evict;
        logic       tick_start;
        logic       drain_clr;
        logic       emit;
        logic [2:0] emit_status;
        logic [2:0] emit_sel;
        logic       emit_last;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       id_ok;
        logic       ids_full;
        logic       hd_empty;
        logic       hin_empty;
        logic       scan_done;
        logic       ev_more;
        logic       found;
        logic       dr_empty;
        logic       dr_last;
        logic       tick_req;
        logic       match;
        logic       pend_valid;
        logic       out_free;
        logic       over_cap;
    } sts_t;

endpackage
`default_nettype wire

### sv/hcae_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcae_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hcae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### sv/hcae_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcae_ctrl
// Sequencer: decodes one word and steps the datapath through its scans.
// ----------------------------------------------------------------------------
module hcae_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire hcae_pkg::sts_t sts,
    output hcae_pkg::cmd_t     cmd
);
    import hcae_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_HD      = 4'd2;
    localparam logic [3:0] S_EV_CHK  = 4'd3;
    localparam logic [3:0] S_EV_RD   = 4'd4;
    localparam logic [3:0] S_EV_CMP  = 4'd5;
    localparam logic [3:0] S_EV_DO   = 4'd6;
    localparam logic [3:0] S_SET_END = 4'd7;
    localparam logic [3:0] S_DR_RD   = 4'd8;
    localparam logic [3:0] S_DR_EM   = 4'd9;
    localparam logic [3:0] S_TK_RD   = 4'd10;
    localparam logic [3:0] S_TK_CMP  = 4'd11;
    localparam logic [3:0] S_TK_END  = 4'd12;

    logic [3:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                case (sts.mode)
                    MODE_NEW: begin
                        if (sts.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            if (sts.ids_full) begin
                                cmd.emit_status = ST_EXHAUST;
                                cmd.emit_sel    = VS_ZERO;
                            end else begin
                                cmd.do_new      = 1'b1;
                                cmd.emit_status = ST_OK;
                                cmd.emit_sel    = VS_NEWID;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    MODE_SET, MODE_RESET, MODE_GET: begin
                        if (sts.id_ok) begin
                            state_next = S_HD;
                        end else if (sts.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_BAD_ID;
                            cmd.emit_sel    = VS_ZERO;
                            state_next      = S_IDLE;
                        end
                    end
                    MODE_DRAIN: begin
                        if (!sts.dr_empty) begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_DR_RD;
                        end else if (sts.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_NOTHING;
                            cmd.emit_sel    = VS_ZERO;
                            state_next      = S_IDLE;
                        end
                    end
                    MODE_TICK: begin
                        cmd.tick_start = 1'b1;
                        cmd.scan_clr   = 1'b1;
                        state_next     = S_TK_RD;
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_NOTHING;
                            cmd.emit_sel    = VS_ZERO;
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end
            S_HD: begin
                case (sts.mode)
                    MODE_SET: begin
                        if (sts.hin_empty || !sts.hd_empty) begin
                            if (sts.out_free) begin
                                cmd.emit        = 1'b1;
                                cmd.emit_last   = 1'b1;
                                cmd.emit_status = sts.hin_empty ? ST_EMPTY_H : ST_BOUND;
                                cmd.emit_sel    = VS_ZERO;
                                state_next      = S_IDLE;
                            end
                        end else begin
                            cmd.do_bind = 1'b1;
                            state_next  = S_EV_CHK;
                        end
                    end
                    MODE_RESET: begin
                        if (sts.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            if (sts.hd_empty) begin
                                cmd.emit_status = ST_NOTHING;
                                cmd.emit_sel    = VS_ZERO;
                            end else begin
                                cmd.do_unbind   = 1'b1;
                                cmd.emit_status = ST_OK;
                                cmd.emit_sel    = VS_HD;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.do_get      = 1'b1;
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_OK;
                            cmd.emit_sel    = VS_HD;
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end
            S_EV_CHK: begin
                if (sts.ev_more) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_EV_RD;
                end else begin
                    state_next = S_SET_END;
                end
            end
            S_EV_RD: begin
                cmd.rd_scan = 1'b1;
                if (!sts.scan_done) begin
                    state_next = S_EV_CMP;
                end else if (sts.found) begin
                    state_next = S_EV_DO;
                end else begin
                    state_next = S_SET_END;
                end
            end
            S_EV_CMP: begin
                cmd.rd_scan  = 1'b1;
                cmd.ev_cmp   = 1'b1;
                cmd.scan_inc = 1'b1;
                state_next   = S_EV_RD;
            end
            S_EV_DO: begin
                cmd.do_evict = 1'b1;
                state_next   = S_EV_CHK;
            end
            S_SET_END: begin
                if (sts.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = sts.over_cap ? ST_OVER_CAP : ST_OK;
                    cmd.emit_sel    = VS_ZERO;
                    state_next      = S_IDLE;
                end
            end
            S_DR_RD: begin
                state_next = S_DR_EM;
            end
            S_DR_EM: begin
                if (sts.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = sts.dr_last;
                    cmd.emit_status = ST_OK;
                    cmd.emit_sel    = VS_EVB;
                    cmd.scan_inc    = 1'b1;
                    if (sts.dr_last) begin
                        cmd.drain_clr = 1'b1;
                        state_next    = S_IDLE;
                    end else begin
                        state_next = S_DR_RD;
                    end
                end
            end
            S_TK_RD: begin
                cmd.rd_scan = 1'b1;
                if (!sts.tick_req || sts.scan_done) begin
                    state_next = S_TK_END;
                end else begin
                    state_next = S_TK_CMP;
                end
            end
            S_TK_CMP: begin
                cmd.rd_scan = 1'b1;
                if (sts.match && sts.pend_valid) begin
                    // push the previous hit out before taking this one
                    if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OK;
                        cmd.emit_sel    = VS_PEND;
                        cmd.tk_load     = 1'b1;
                        cmd.scan_inc    = 1'b1;
                        state_next      = S_TK_RD;
                    end
                end else begin
                    cmd.tk_load  = sts.match;
                    cmd.scan_inc = 1'b1;
                    state_next   = S_TK_RD;
                end
            end
            S_TK_END: begin
                if (sts.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = sts.pend_valid ? ST_OK : ST_NOTHING;
                    cmd.emit_sel    = sts.pend_valid ? VS_PEND : VS_ZERO;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### sv/hcae_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcae_dp
// Datapath: tables, counters, oldest-entry search, tick scan, result register.
// ----------------------------------------------------------------------------
module hcae_dp #(
    parameter int ENTRIES     = 64,
    parameter int EVICT_DEPTH = 64
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire hcae_pkg::cmd_t cmd,
    output hcae_pkg::sts_t      sts,
    input  wire logic [15:0]    capacity,
    input  wire logic [15:0]    reserve_level,
    input  wire logic [2:0]     s_mode,
    input  wire logic [6:0]     s_id,
    input  wire logic [15:0]    s_handle,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [2:0]          m_status,
    output logic [15:0]         m_value,
    output logic                m_last
);
    import hcae_pkg::*;

    localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int EAW = (EVICT_DEPTH > 1) ? $clog2(EVICT_DEPTH) : 1;
    localparam int EW  = $clog2(EVICT_DEPTH + 1);

    // item latch
    logic [2:0]  mode_reg;
    logic [6:0]  id_reg;
    logic [15:0] hin_reg;

    // bookkeeping
    logic [CW-1:0] ids_reg, live_reg, scan_reg;
    logic [EW-1:0] evc_reg, dr_reg;
    logic [31:0]   frame_reg, tick_f_reg, best_age_reg;
    logic          req_reg, tick_req_reg, found_reg, pend_v_reg;
    logic [AW-1:0] best_idx_reg;
    logic [15:0]   best_hd_reg, pend_reg;

    // result register
    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [15:0] m_value_reg;
    logic        m_last_reg;

    logic [AW-1:0]  id_idx, hd_raddr, hd_waddr, st_waddr;
    logic [15:0]    hd_wdata, hd_rdata, evb_rdata, val_mux;
    logic           hd_we, st_we;
    logic [31:0]    st_rdata, age;
    logic           cand;

    assign id_idx = AW'(id_reg - 7'd1);
    assign age    = frame_reg - st_rdata;
    assign cand   = (hd_rdata != EMPTY_HANDLE) && (!found_reg || (age > best_age_reg));

    always_comb begin
        hd_we    = cmd.do_new | cmd.do_bind | cmd.do_unbind | cmd.do_evict;
        hd_waddr = id_idx;
        hd_wdata = EMPTY_HANDLE;
        if (cmd.do_new) begin
            hd_waddr = ids_reg[AW-1:0];
        end else if (cmd.do_evict) begin
            hd_waddr = best_idx_reg;
        end else if (cmd.do_bind) begin
            hd_wdata = hin_reg;
        end
        st_we    = cmd.do_new | cmd.do_get;
        st_waddr = cmd.do_new ? ids_reg[AW-1:0] : id_idx;
        hd_raddr = cmd.rd_scan ? scan_reg[AW-1:0] : id_idx;
    end

    hcae_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_handle_ram (
        .aclk  (aclk),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hd_wdata),
        .raddr (hd_raddr),
        .rdata (hd_rdata)
    );

    hcae_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_stamp_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (frame_reg),
        .raddr (scan_reg[AW-1:0]),
        .rdata (st_rdata)
    );

    hcae_ram #(.WIDTH(16), .DEPTH(EVICT_DEPTH)) u_evict_ram (
        .aclk  (aclk),
        .we    (cmd.do_evict),
        .waddr (evc_reg[EAW-1:0]),
        .wdata (best_hd_reg),
        .raddr (dr_reg[EAW-1:0]),
        .rdata (evb_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg <= s_mode;
            id_reg   <= s_id;
            hin_reg  <= s_handle;
        end
        if (cmd.ev_cmp && cand) begin
            best_idx_reg <= scan_reg[AW-1:0];
            best_age_reg <= age;
            best_hd_reg  <= hd_rdata;
        end
        if (cmd.tick_start) begin
            tick_f_reg <= frame_reg;
        end
        if (cmd.tk_load) begin
            pend_reg <= 16'(32'(scan_reg) + 1);
        end
        if (cmd.scan_clr) begin
            scan_reg <= '0;
            dr_reg   <= '0;
        end else if (cmd.scan_inc) begin
            scan_reg <= scan_reg + 1'b1;
            dr_reg   <= dr_reg + 1'b1;
        end
        if (cmd.emit) begin
            m_status_reg <= cmd.emit_status;
            m_value_reg  <= val_mux;
            m_last_reg   <= cmd.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ids_reg      <= '0;
            live_reg     <= '0;
            evc_reg      <= '0;
            frame_reg    <= '0;
            req_reg      <= 1'b0;
            tick_req_reg <= 1'b0;
            found_reg    <= 1'b0;
            pend_v_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.do_new) begin
                ids_reg <= ids_reg + 1'b1;
            end
            if (cmd.do_bind) begin
                live_reg <= live_reg + 1'b1;
            end else if (cmd.do_unbind || cmd.do_evict) begin
                live_reg <= live_reg - 1'b1;
            end
            if (cmd.do_evict) begin
                evc_reg <= evc_reg + 1'b1;
            end else if (cmd.drain_clr) begin
                evc_reg <= '0;
            end
            if (cmd.do_get && (hd_rdata != EMPTY_HANDLE)) begin
                req_reg <= 1'b1;
            end else if (cmd.tick_start) begin
                req_reg <= 1'b0;
            end
            if (cmd.tick_start) begin
                frame_reg    <= frame_reg + 32'd1;
                tick_req_reg <= req_reg;
                pend_v_reg   <= 1'b0;
            end else if (cmd.tk_load) begin
                pend_v_reg <= 1'b1;
            end
            if (cmd.scan_clr) begin
                found_reg <= 1'b0;
            end else if (cmd.ev_cmp && cand) begin
                found_reg <= 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        case (cmd.emit_sel)
            VS_NEWID: val_mux = 16'(32'(ids_reg) + 1);
            VS_HD:    val_mux = hd_rdata;
            VS_EVB:   val_mux = evb_rdata;
            VS_PEND:  val_mux = pend_reg;
            default:  val_mux = 16'd0;
        endcase
    end

    always_comb begin
        sts.mode       = mode_reg;
        sts.id_ok      = (id_reg != 7'd0) && (32'(id_reg) <= 32'(ids_reg));
        sts.ids_full   = 32'(ids_reg) >= ENTRIES;
        sts.hd_empty   = (hd_rdata == EMPTY_HANDLE);
        sts.hin_empty  = (hin_reg == EMPTY_HANDLE);
        sts.scan_done  = (scan_reg >= ids_reg);
        sts.ev_more    = (32'(live_reg) > 32'(reserve_level)) && (32'(evc_reg) < EVICT_DEPTH);
        sts.found      = found_reg;
        sts.dr_empty   = (evc_reg == '0);
        sts.dr_last    = (32'(dr_reg) + 1) == 32'(evc_reg);
        sts.tick_req   = tick_req_reg;
        sts.match      = (st_rdata == tick_f_reg) && (hd_rdata == EMPTY_HANDLE);
        sts.pend_valid = pend_v_reg;
        sts.out_free   = !m_valid_reg || m_ready;
        sts.over_cap   = (32'(live_reg) + 32'(evc_reg)) > 32'(capacity);
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_value  = m_value_reg;
    assign m_last   = m_last_reg;

endmodule
`default_nettype wire

### sv/handle_cache_age_evictor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// handle_cache_age_evictor_top
// Id-to-handle table with frame stamps and oldest-first eviction.
// ----------------------------------------------------------------------------
// One word in gives one or more result words, the final one flagged by
// m_last. The block takes one word at a time; it is ready again once the
// final result sits in the output register. Every handle that set evicts
// costs one pass over the stamp and handle RAMs, reading each allocated id
// in turn (one RAM read port each). drain emits one result word per
// evicted handle; a tick with the request flag up walks all allocated ids,
// and a tick without it does not walk them. Stalls on m_ready hold the
// sequence. Configuration (capacity at 0x0, reserve_level at 0x4) is
// written over the APB port; the user must write it only while the block
// is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module handle_cache_age_evictor_top #(
    parameter int ENTRIES     = 64,
    parameter int EVICT_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // item channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_mode,
    input  wire logic [6:0]  s_id,
    input  wire logic [15:0] s_handle,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [15:0]      m_value,
    output logic             m_last,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import hcae_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [15:0] capacity_reg, reserve_reg;

    // register select is paddr[2]: capacity, then reserve_level
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= 16'd64;
            reserve_reg  <= 16'd32;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                reserve_reg <= pwdata[15:0];
            end else begin
                capacity_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = {16'd0, paddr[2] ? reserve_reg : capacity_reg};

    hcae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hcae_dp #(
        .ENTRIES     (ENTRIES),
        .EVICT_DEPTH (EVICT_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .capacity      (capacity_reg),
        .reserve_level (reserve_reg),
        .s_mode        (s_mode),
        .s_id          (s_id),
        .s_handle      (s_handle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_value       (m_value),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire
